// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the block's top module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while out of reset.
`define P2LD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("p2ld assertion failed");

// Checks that a condition never holds while out of reset.
`define P2LD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("p2ld forbidden condition seen");

`endif

// File: design/p2ld_pkg.sv
// ---------------------------------------------------------------------------
// p2ld_pkg
// Shared types of the point-to-line distance block.
// ---------------------------------------------------------------------------
package p2ld_pkg;

    // Per-item flags that travel down the pipeline with the data.
    typedef struct packed {
        logic degen;
        logic ovf;
    } t_ctl;

endpackage

// File: design/p2ld_if.sv
// ---------------------------------------------------------------------------
// p2ld_if
// Valid/ready channels for query items and distance results.
// ---------------------------------------------------------------------------
interface p2ld_in_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] first_x;
    logic [W-1:0] first_y;
    logic [W-1:0] first_z;
    logic [W-1:0] second_x;
    logic [W-1:0] second_y;
    logic [W-1:0] second_z;
    logic [W-1:0] query_x;
    logic [W-1:0] query_y;
    logic [W-1:0] query_z;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, query_x, query_y, query_z, input ready);
    modport sink (input valid, first_x, first_y, first_z, second_x, second_y,
                  second_z, query_x, query_y, query_z, output ready);
endinterface

interface p2ld_out_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] distance;
    logic         degenerate;
    logic         saturated;

    modport source (output valid, distance, degenerate, saturated, input ready);
    modport sink (input valid, distance, degenerate, saturated, output ready);
endinterface

// File: design/p2ld_front.sv
// ---------------------------------------------------------------------------
// p2ld_front
// Differences, cross product, squared norms and the overflow test.
// ---------------------------------------------------------------------------
module p2ld_front #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [W-1:0]        i_p1 [3],
    input  logic [W-1:0]        i_p2 [3],
    input  logic [W-1:0]        i_q  [3],
    output logic                o_valid,
    output p2ld_pkg::t_ctl      o_ctl,
    output logic [4*W+5:0]      o_num,
    output logic [2*W+1:0]      o_den
);
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;
    localparam int H  = DW;
    localparam int SQ = 4 * H;
    localparam int NW = SQ + 2;
    localparam int QB = 2 * W;

    logic [6:0] r_v;
    logic       r_dg2;
    logic       r_dg3;
    logic       r_dg4;
    logic       r_dg5;
    logic       r_dg6;
    logic       r_dg7;

    // Stage 1: line direction and offset of the query point.
    logic signed [DW-1:0] r_d [3];
    logic signed [DW-1:0] r_e [3];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= $signed({i_p1[i][W-1], i_p1[i]}) - $signed({i_p2[i][W-1], i_p2[i]});
                r_e[i] <= $signed({i_q[i][W-1], i_q[i]}) - $signed({i_p1[i][W-1], i_p1[i]});
            end
        end
    end

    // Stage 2: the six cross-product terms and the squared components.
    logic signed [PW-1:0] r_pr [6];
    logic        [PW-1:0] r_sq [3];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pr[0] <= r_d[1] * r_e[2];
            r_pr[1] <= r_d[2] * r_e[1];
            r_pr[2] <= r_d[2] * r_e[0];
            r_pr[3] <= r_d[0] * r_e[2];
            r_pr[4] <= r_d[0] * r_e[1];
            r_pr[5] <= r_d[1] * r_e[0];
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= $unsigned(PW'(r_d[i]) * PW'(r_d[i]));
            end
            r_dg2 <= (r_d[0] == '0) && (r_d[1] == '0) && (r_d[2] == '0);
        end
    end

    // Stage 3: cross-product magnitudes and the squared direction length.
    logic [PW-1:0] r_mag [3];
    logic [PW-1:0] r_den3;
    always_ff @(posedge i_clk) begin
        logic signed [CW-1:0] v_diff;
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                v_diff = $signed({r_pr[2*c][PW-1], r_pr[2*c]})
                       - $signed({r_pr[2*c+1][PW-1], r_pr[2*c+1]});
                r_mag[c] <= v_diff[CW-1] ? PW'(-v_diff) : PW'(v_diff);
            end
            r_den3 <= r_sq[0] + r_sq[1] + r_sq[2];
            r_dg3 <= r_dg2;
        end
    end

    // Stage 4: partial products of each magnitude squared, split in halves.
    logic [2*H-1:0] r_hh [3];
    logic [2*H-1:0] r_hl [3];
    logic [2*H-1:0] r_ll [3];
    logic [PW-1:0]  r_den4;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_hh[c] <= r_mag[c][2*H-1:H] * r_mag[c][2*H-1:H];
                r_hl[c] <= r_mag[c][2*H-1:H] * r_mag[c][H-1:0];
                r_ll[c] <= r_mag[c][H-1:0] * r_mag[c][H-1:0];
            end
            r_den4 <= r_den3;
            r_dg4 <= r_dg3;
        end
    end

    // Stage 5: assemble the squared cross-product components.
    logic [SQ-1:0] r_csq [3];
    logic [PW-1:0] r_den5;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_csq[c] <= (SQ'(r_hh[c]) << (2*H)) + (SQ'(r_hl[c]) << (H+1)) + SQ'(r_ll[c]);
            end
            r_den5 <= r_den4;
            r_dg5 <= r_dg4;
        end
    end

    // Stage 6: squared norm of the cross product.
    logic [NW-1:0] r_num6;
    logic [PW-1:0] r_den6;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num6 <= NW'(r_csq[0]) + NW'(r_csq[1]) + NW'(r_csq[2]);
            r_den6 <= r_den5;
            r_dg6 <= r_dg5;
        end
    end

    // Stage 7: a quotient of 2^(2W) or more means the distance saturates.
    logic [NW-1:0] r_num7;
    logic [PW-1:0] r_den7;
    logic          r_ovf;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num7 <= r_num6;
            r_den7 <= r_den6;
            r_ovf  <= r_num6 >= (NW'(r_den6) << QB);
            r_dg7 <= r_dg6;
        end
    end

    // Valid bits of the seven stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    assign o_valid     = r_v[6];
    assign o_ctl.degen = r_dg7;
    assign o_ctl.ovf   = r_ovf;
    assign o_num       = r_num7;
    assign o_den       = r_den7;
endmodule

// File: design/p2ld_div.sv
// ---------------------------------------------------------------------------
// p2ld_div
// Restoring divider, one quotient bit per pipeline stage.
// ---------------------------------------------------------------------------
module p2ld_div #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  p2ld_pkg::t_ctl      i_ctl,
    input  logic [4*W+5:0]      i_num,
    input  logic [2*W+1:0]      i_den,
    output logic                o_valid,
    output p2ld_pkg::t_ctl      o_ctl,
    output logic [2*W-1:0]      o_quo
);
    localparam int NW = 4 * W + 6;
    localparam int DN = 2 * W + 2;
    localparam int QB = 2 * W;

    logic [NW-1:0]  a_rem [QB+1];
    logic [DN-1:0]  a_den [QB+1];
    logic [QB-1:0]  a_quo [QB+1];
    p2ld_pkg::t_ctl a_ctl [QB+1];
    logic [QB:0]    a_v;

    assign a_rem[0] = i_num;
    assign a_den[0] = i_den;
    assign a_quo[0] = '0;
    assign a_ctl[0] = i_ctl;
    assign a_v[0]   = i_valid;

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int I = QB - 1 - k;
        logic [NW-1:0]  w_sh;
        logic           w_ge;
        logic [NW-1:0]  r_rem;
        logic [DN-1:0]  r_den;
        logic [QB-1:0]  r_quo;
        p2ld_pkg::t_ctl r_ctl;
        logic           r_v;

        // Try to take the divisor, shifted to this bit, off the remainder.
        assign w_sh = NW'(a_den[k]) << I;
        assign w_ge = a_rem[k] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_ge ? (a_rem[k] - w_sh) : a_rem[k];
                r_den <= a_den[k];
                r_quo <= {a_quo[k][QB-2:0], w_ge};
                r_ctl <= a_ctl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= a_v[k];
            end
        end

        assign a_rem[k+1] = r_rem;
        assign a_den[k+1] = r_den;
        assign a_quo[k+1] = r_quo;
        assign a_ctl[k+1] = r_ctl;
        assign a_v[k+1]   = r_v;
    end

    assign o_valid = a_v[QB];
    assign o_ctl   = a_ctl[QB];
    assign o_quo   = a_quo[QB];
endmodule

// File: design/p2ld_sqrt.sv
// ---------------------------------------------------------------------------
// p2ld_sqrt
// Integer square root, one root bit per pipeline stage.
// ---------------------------------------------------------------------------
module p2ld_sqrt #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  p2ld_pkg::t_ctl      i_ctl,
    input  logic [2*W-1:0]      i_rad,
    output logic                o_valid,
    output p2ld_pkg::t_ctl      o_ctl,
    output logic [W-1:0]        o_root
);
    localparam int QB = 2 * W;
    localparam int RW = W + 2;
    localparam int TW = W + 4;

    logic [QB-1:0]  a_rad  [W+1];
    logic [RW-1:0]  a_rem  [W+1];
    logic [W-1:0]   a_root [W+1];
    p2ld_pkg::t_ctl a_ctl  [W+1];
    logic [W:0]     a_v;

    assign a_rad[0]  = i_rad;
    assign a_rem[0]  = '0;
    assign a_root[0] = '0;
    assign a_ctl[0]  = i_ctl;
    assign a_v[0]    = i_valid;

    for (genvar j = 0; j < W; j++) begin : g_stage
        logic [TW-1:0]  w_tmp;
        logic [TW-1:0]  w_trial;
        logic           w_ge;
        logic [QB-1:0]  r_rad;
        logic [RW-1:0]  r_rem;
        logic [W-1:0]   r_root;
        p2ld_pkg::t_ctl r_ctl;
        logic           r_v;

        // Bring down the next two radicand bits and test 4*root + 1.
        assign w_tmp   = {a_rem[j], a_rad[j][QB-1:QB-2]};
        assign w_trial = TW'({a_root[j], 2'b01});
        assign w_ge    = w_tmp >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad  <= a_rad[j] << 2;
                r_rem  <= w_ge ? RW'(w_tmp - w_trial) : RW'(w_tmp);
                r_root <= {a_root[j][W-2:0], w_ge};
                r_ctl  <= a_ctl[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= a_v[j];
            end
        end

        assign a_rad[j+1]  = r_rad;
        assign a_rem[j+1]  = r_rem;
        assign a_root[j+1] = r_root;
        assign a_ctl[j+1]  = r_ctl;
        assign a_v[j+1]    = r_v;
    end

    assign o_valid = a_v[W];
    assign o_ctl   = a_ctl[W];
    assign o_root  = a_root[W];
endmodule

// File: design/point_to_line_distance_3d.sv
// ---------------------------------------------------------------------------
// point_to_line_distance_3d
// Distance from a query point to the 3D line through two points.
//
//   channel  dir  payload
//   i_in     in   first_*, second_*, query_* (x, y, z), signed fixed point
//   o_out    out  distance (unsigned, saturating), degenerate, saturated
//
// One item enters per cycle while the output is not stalled; the result passes
// through the front stages, the one-bit-per-stage divider and square root,
// and then the output register.
// Reset clears only the valid bits of the stages and the output register.
// The whole pipeline advances when the output register is empty or taken,
// so a stalled result holds the pipeline and no item is lost or repeated.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module point_to_line_distance_3d #(
    parameter int COORD_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    p2ld_in_if.sink     i_in,
    p2ld_out_if.source  o_out
);
    localparam int W = COORD_WIDTH;

    logic                w_en;
    logic [W-1:0]        w_p1 [3];
    logic [W-1:0]        w_p2 [3];
    logic [W-1:0]        w_q  [3];
    logic                w_f_v;
    p2ld_pkg::t_ctl      w_f_ctl;
    logic [4*W+5:0]      w_num;
    logic [2*W+1:0]      w_den;
    logic                w_d_v;
    p2ld_pkg::t_ctl      w_d_ctl;
    logic [2*W-1:0]      w_quo;
    logic                w_s_v;
    p2ld_pkg::t_ctl      w_s_ctl;
    logic [W-1:0]        w_root;

    logic                r_ov;
    logic [W-1:0]        r_dist;
    logic                r_degen;
    logic                r_sat;

    // Advance everything whenever the output register can take a new item.
    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    assign w_p1[0] = i_in.first_x;
    assign w_p1[1] = i_in.first_y;
    assign w_p1[2] = i_in.first_z;
    assign w_p2[0] = i_in.second_x;
    assign w_p2[1] = i_in.second_y;
    assign w_p2[2] = i_in.second_z;
    assign w_q[0]  = i_in.query_x;
    assign w_q[1]  = i_in.query_y;
    assign w_q[2]  = i_in.query_z;

    p2ld_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_p1    (w_p1),
        .i_p2    (w_p2),
        .i_q     (w_q),
        .o_valid (w_f_v),
        .o_ctl   (w_f_ctl),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    p2ld_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_v),
        .i_ctl   (w_f_ctl),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_valid (w_d_v),
        .o_ctl   (w_d_ctl),
        .o_quo   (w_quo)
    );

    p2ld_sqrt #(.W(W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_v),
        .i_ctl   (w_d_ctl),
        .i_rad   (w_quo),
        .o_valid (w_s_v),
        .o_ctl   (w_s_ctl),
        .o_root  (w_root)
    );

    // Output register: coincident points give zero, overflow gives all ones.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_degen <= w_s_ctl.degen;
            r_sat   <= w_s_ctl.ovf && !w_s_ctl.degen;
            if (w_s_ctl.degen) begin
                r_dist <= '0;
            end else if (w_s_ctl.ovf) begin
                r_dist <= '1;
            end else begin
                r_dist <= w_root;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_s_v;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.distance   = r_dist;
    assign o_out.degenerate = r_degen;
    assign o_out.saturated  = r_sat;

    `P2LD_ASSERT(a_degen_zero, i_clk, i_rst_n, (r_ov && r_degen) |-> (r_dist == '0))
    `P2LD_ASSERT(a_sat_max, i_clk, i_rst_n, (r_ov && r_sat) |-> (r_dist == '1))
    `P2LD_NEVER(a_sat_degen, i_clk, i_rst_n, r_ov && r_sat && r_degen)
    `P2LD_ASSERT(a_stall_ready, i_clk, i_rst_n, (r_ov && !o_out.ready) |-> !i_in.ready)
endmodule
